[design/uer_pkg.sv]
package uer_pkg;

  // field and register widths
  localparam int TEMP_W  = 12;
  localparam int TIME_W  = 16;
  localparam int SC_W    = 5;
  localparam int DIST_W  = 14;
  localparam int ST_W    = 3;
  localparam int IDX_W   = 3;
  localparam int CFG_W   = 16;

  // speed of sound in 1/256 m/s, time of flight product and divider sizes
  localparam int SPEED_W = 17;
  localparam int SLOPE_W = 20;
  localparam int BASE_W  = 18;
  localparam int PROD_W  = TIME_W + SPEED_W;
  localparam int DQ_W    = 15;
  localparam int DSR_W   = 19;

  localparam logic signed [BASE_W-1:0]  SPEED_BASE  = 18'sd84813;
  localparam logic signed [SLOPE_W-1:0] SPEED_SLOPE = 20'sd155;
  localparam logic [DSR_W-1:0]          TOF_DIV     = 19'd320000;

  // status codes
  localparam logic [ST_W-1:0] ST_OK       = 3'd0;
  localparam logic [ST_W-1:0] ST_START_TO = 3'd1;
  localparam logic [ST_W-1:0] ST_END_TO   = 3'd2;
  localparam logic [ST_W-1:0] ST_RANGE    = 3'd3;
  localparam logic [ST_W-1:0] ST_NONE     = 3'd4;

  // register indexes
  localparam logic [IDX_W-1:0] REG_TEMP     = 3'd0;
  localparam logic [IDX_W-1:0] REG_START_TO = 3'd1;
  localparam logic [IDX_W-1:0] REG_END_TO   = 3'd2;
  localparam logic [IDX_W-1:0] REG_GUARD    = 3'd3;
  localparam logic [IDX_W-1:0] REG_SCOUNT   = 3'd4;
  localparam logic [IDX_W-1:0] REG_MIN      = 3'd5;
  localparam logic [IDX_W-1:0] REG_MAX      = 3'd6;

  // register reset values
  localparam logic [TEMP_W-1:0] RST_TEMP     = 12'd320;
  localparam logic [TIME_W-1:0] RST_START_TO = 16'd10000;
  localparam logic [TIME_W-1:0] RST_END_TO   = 16'd38000;
  localparam logic [TIME_W-1:0] RST_GUARD    = 16'd60000;
  localparam logic [SC_W-1:0]   RST_SCOUNT   = 5'd1;
  localparam logic [DIST_W-1:0] RST_MIN      = 14'd320;
  localparam logic [DIST_W-1:0] RST_MAX      = 14'd9600;

  typedef struct packed {
    logic              go;
    logic [PROD_W-1:0] dividend;
    logic [DSR_W-1:0]  divisor;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [PROD_W-1:0] quotient;
  } div_rsp_t;

endpackage

[design/uer_if.sv]
interface uer_in_if;
  logic valid;
  logic ready;
  logic start_req;
  logic echo;

  modport source (output valid, output start_req, output echo, input ready);
  modport sink (input valid, input start_req, input echo, output ready);
endinterface

interface uer_out_if import uer_pkg::*; ;
  logic              valid;
  logic              ready;
  logic              trigger;
  logic              done_res;
  logic [ST_W-1:0]   status;
  logic [DIST_W-1:0] distance_q4;
  logic [SC_W-1:0]   valid_count;

  modport source (
    output valid, output trigger, output done_res, output status,
    output distance_q4, output valid_count, input ready
  );
  modport sink (
    input valid, input trigger, input done_res, input status,
    input distance_q4, input valid_count, output ready
  );
endinterface

[design/uer_div.sv]
module uer_div import uer_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  localparam int CNT_W = $clog2(PROD_W + 1);

  logic [CNT_W-1:0]  cnt_q;
  logic              done_q;
  logic [DSR_W-1:0]  rem_q, rem_d;
  logic [DSR_W-1:0]  dsr_q;
  logic [PROD_W-1:0] quo_q;
  logic [DSR_W:0]    trial, diff;
  logic              take;

  // restoring division, one quotient bit per cycle
  always_comb begin
    trial = {rem_q, quo_q[PROD_W-1]};
    diff  = trial - {1'b0, dsr_q};
    take  = trial >= {1'b0, dsr_q};
    rem_d = take ? diff[DSR_W-1:0] : trial[DSR_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (req_i.go) begin
        cnt_q <= CNT_W'(PROD_W);
      end else if (cnt_q != '0) begin
        cnt_q <= cnt_q - CNT_W'(1);
        if (cnt_q == CNT_W'(1)) begin
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.go) begin
      rem_q <= '0;
      quo_q <= req_i.dividend;
      dsr_q <= req_i.divisor;
    end else if (cnt_q != '0) begin
      rem_q <= rem_d;
      quo_q <= {quo_q[PROD_W-2:0], take};
    end
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quo_q;

`ifndef SYNTHESIS
  a_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.go |=> cnt_q == CNT_W'(PROD_W))
    else $error("divider did not load its step count");

  a_rem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q != '0 && dsr_q != '0) |-> rem_q < dsr_q)
    else $error("partial remainder not below divisor");

  a_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> cnt_q == '0)
    else $error("divider done while still stepping");
`endif

endmodule

[design/ultrasonic_echo_ranger.sv]
// Ultrasonic time-of-flight ranger, one input word per microsecond tick and exactly one
// output word per tick (trigger level, and at the end of a run the done flag, status,
// averaged distance in 1/16 cm and valid sample count). A tick that does not end a
// measurement goes straight to the output stage. A tick that ends a measurement by a
// timeout closes it, and when it also ends a run with valid samples, a divider pass
// forms the mean. A tick on which the echo falls runs the pulse length through a
// bit-serial multiplier (16 steps, one per cycle) and a shared 33-step restoring divider
// for the division by 320000; if that tick also ends a run with valid samples, a second
// divider pass forms the mean. A stalled output holds back the result, and with it the
// next word. The next word is taken while the previous result still waits in the output
// register.
module ultrasonic_echo_ranger import uer_pkg::*; #(
  parameter int TRIGGER_TICKS = 10,
  parameter int MAX_SAMPLES   = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0] cfg_data_i,
  uer_in_if.sink           in_i,
  uer_out_if.source        out_o
);

  localparam int SUM_W  = DIST_W + $clog2(MAX_SAMPLES + 1);
  localparam int MCNT_W = $clog2(TIME_W + 1);

  typedef enum logic [2:0] {
    PH_IDLE, PH_GUARD, PH_TRIG, PH_WAIT, PH_COUNT
  } phase_e;

  typedef enum logic [2:0] {
    C_IN, C_MUL, C_DIV, C_END, C_AVG, C_OUT
  } ctl_e;

  // configuration
  logic signed [TEMP_W-1:0] temp_q;
  logic [TIME_W-1:0]        start_to_q, end_to_q, guard_q;
  logic [SC_W-1:0]          scount_q;
  logic [DIST_W-1:0]        min_q, max_q;

  // control and run state
  ctl_e               ctl_q;
  phase_e             ph_q, ph_d;
  logic [TIME_W-1:0]  tick_q, tick_d;
  logic [SC_W-1:0]    si_q, vs_q;
  logic [SUM_W-1:0]   sum_q;
  logic [ST_W-1:0]    code_q;
  logic [DQ_W-1:0]    d_q;

  // multiplier
  logic [SPEED_W-1:0] mcand_q;
  logic [SPEED_W-1:0] prod_hi_q;
  logic [TIME_W-1:0]  prod_lo_q;
  logic [MCNT_W-1:0]  mcnt_q;
  logic [SPEED_W:0]   mul_sum;

  // divider request
  logic               div_go_q;
  logic [PROD_W-1:0]  div_dvd_q;
  logic [DSR_W-1:0]   div_dsr_q;
  div_req_t           div_req;
  div_rsp_t           div_rsp;

  // staged result and output register
  logic               res_trig_q, res_done_q;
  logic [ST_W-1:0]    res_status_q;
  logic [DIST_W-1:0]  res_dist_q;
  logic [SC_W-1:0]    res_vc_q;
  logic               out_valid_q, o_trig_q, o_done_q;
  logic [ST_W-1:0]    o_status_q;
  logic [DIST_W-1:0]  o_dist_q;
  logic [SC_W-1:0]    o_vc_q;

  // combinational helpers
  logic [SC_W-1:0]           run_len;
  logic [TIME_W:0]           tick_inc;
  logic                      end_ev, run_clr;
  logic [ST_W-1:0]           end_code;
  logic signed [SLOPE_W-1:0] temp_ext, slope_p;
  logic signed [BASE_W-1:0]  spd;
  logic [SPEED_W-1:0]        speed;
  logic                      oor, keep, fin;
  logic [ST_W-1:0]           code_eff;
  logic [SC_W-1:0]           vs_n, si_n;
  logic [SUM_W-1:0]          sum_n;
  phase_e                    ph_guard;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      temp_q     <= RST_TEMP;
      start_to_q <= RST_START_TO;
      end_to_q   <= RST_END_TO;
      guard_q    <= RST_GUARD;
      scount_q   <= RST_SCOUNT;
      min_q      <= RST_MIN;
      max_q      <= RST_MAX;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_TEMP:     temp_q     <= cfg_data_i[TEMP_W-1:0];
        REG_START_TO: start_to_q <= cfg_data_i[TIME_W-1:0];
        REG_END_TO:   end_to_q   <= cfg_data_i[TIME_W-1:0];
        REG_GUARD:    guard_q    <= cfg_data_i[TIME_W-1:0];
        REG_SCOUNT:   scount_q   <= cfg_data_i[SC_W-1:0];
        REG_MIN:      min_q      <= cfg_data_i[DIST_W-1:0];
        REG_MAX:      max_q      <= cfg_data_i[DIST_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    priority if (scount_q == '0) begin
      run_len = SC_W'(1);
    end else if (int'(scount_q) > MAX_SAMPLES) begin
      run_len = SC_W'(MAX_SAMPLES);
    end else begin
      run_len = scount_q;
    end
  end

  // speed = 84813 + floor(155 * temp / 16)
  always_comb begin
    temp_ext = SLOPE_W'(temp_q);
    slope_p  = temp_ext * SPEED_SLOPE;
    spd      = SPEED_BASE + BASE_W'(slope_p >>> 4);
    speed    = spd[SPEED_W-1:0];
  end

  assign ph_guard = (guard_q == '0) ? PH_TRIG : PH_GUARD;
  assign tick_inc = {1'b0, tick_q} + (TIME_W+1)'(1);

  // tick sequencing
  always_comb begin
    ph_d     = ph_q;
    tick_d   = tick_q;
    end_ev   = 1'b0;
    end_code = ST_OK;
    run_clr  = 1'b0;
    unique case (ph_q)
      PH_IDLE: begin
        if (in_i.start_req) begin
          run_clr = 1'b1;
          tick_d  = '0;
          ph_d    = ph_guard;
        end
      end
      PH_GUARD: begin
        tick_d = tick_inc[TIME_W-1:0];
        if (tick_inc >= {1'b0, guard_q}) begin
          tick_d = '0;
          ph_d   = PH_TRIG;
        end
      end
      PH_TRIG: begin
        tick_d = tick_inc[TIME_W-1:0];
        if (tick_inc >= (TIME_W+1)'(TRIGGER_TICKS)) begin
          tick_d = '0;
          ph_d   = PH_WAIT;
        end
      end
      PH_WAIT: begin
        if (in_i.echo) begin
          tick_d = '0;
          ph_d   = PH_COUNT;
        end else begin
          tick_d = tick_inc[TIME_W-1:0];
          if (tick_inc >= {1'b0, start_to_q}) begin
            end_ev   = 1'b1;
            end_code = ST_START_TO;
          end
        end
      end
      PH_COUNT: begin
        if (!in_i.echo) begin
          end_ev   = 1'b1;
          end_code = ST_OK;
        end else begin
          tick_d = tick_inc[TIME_W-1:0];
          if (tick_inc >= {1'b0, end_to_q}) begin
            end_ev   = 1'b1;
            end_code = ST_END_TO;
          end
        end
      end
      default: begin
        ph_d   = PH_IDLE;
        tick_d = '0;
      end
    endcase
  end

  // close of one measurement
  always_comb begin
    oor      = (d_q < DQ_W'(min_q)) || (d_q > DQ_W'(max_q));
    keep     = (code_q == ST_OK) && !oor;
    code_eff = (code_q == ST_OK && oor) ? ST_RANGE : code_q;
    vs_n     = vs_q + SC_W'(keep);
    sum_n    = sum_q + (keep ? SUM_W'(d_q) : '0);
    si_n     = si_q + SC_W'(1);
    fin      = si_n >= run_len;
  end

  assign mul_sum = {1'b0, prod_hi_q} + (prod_lo_q[0] ? {1'b0, mcand_q} : '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q        <= C_IN;
      ph_q         <= PH_IDLE;
      tick_q       <= '0;
      si_q         <= '0;
      vs_q         <= '0;
      sum_q        <= '0;
      code_q       <= ST_OK;
      d_q          <= '0;
      mcand_q      <= '0;
      prod_hi_q    <= '0;
      prod_lo_q    <= '0;
      mcnt_q       <= '0;
      div_go_q     <= 1'b0;
      div_dvd_q    <= '0;
      div_dsr_q    <= '0;
      res_trig_q   <= 1'b0;
      res_done_q   <= 1'b0;
      res_status_q <= ST_OK;
      res_dist_q   <= '0;
      res_vc_q     <= '0;
      out_valid_q  <= 1'b0;
      o_trig_q     <= 1'b0;
      o_done_q     <= 1'b0;
      o_status_q   <= ST_OK;
      o_dist_q     <= '0;
      o_vc_q       <= '0;
    end else begin
      if (out_valid_q && out_o.ready && ctl_q != C_OUT) begin
        out_valid_q <= 1'b0;
      end
      unique case (ctl_q)
        C_IN: begin
          if (in_i.valid) begin
            res_trig_q   <= (ph_q == PH_TRIG);
            res_done_q   <= 1'b0;
            res_status_q <= ST_OK;
            res_dist_q   <= '0;
            res_vc_q     <= '0;
            ph_q         <= ph_d;
            tick_q       <= tick_d;
            if (run_clr) begin
              si_q  <= '0;
              vs_q  <= '0;
              sum_q <= '0;
            end
            if (end_ev) begin
              code_q <= end_code;
              if (end_code == ST_OK) begin
                mcand_q   <= speed;
                prod_hi_q <= '0;
                prod_lo_q <= tick_q;
                mcnt_q    <= MCNT_W'(TIME_W);
                ctl_q     <= C_MUL;
              end else begin
                ctl_q <= C_END;
              end
            end else begin
              ctl_q <= C_OUT;
            end
          end
        end
        C_MUL: begin
          if (mcnt_q != '0) begin
            // multiplier bits leave the low word as product bits enter it
            prod_hi_q <= mul_sum[SPEED_W:1];
            prod_lo_q <= {mul_sum[0], prod_lo_q[TIME_W-1:1]};
            mcnt_q    <= mcnt_q - MCNT_W'(1);
          end else begin
            div_go_q  <= 1'b1;
            div_dvd_q <= {prod_hi_q, prod_lo_q};
            div_dsr_q <= TOF_DIV;
            ctl_q     <= C_DIV;
          end
        end
        C_DIV: begin
          div_go_q <= 1'b0;
          if (div_rsp.done) begin
            d_q   <= div_rsp.quotient[DQ_W-1:0];
            ctl_q <= C_END;
          end
        end
        C_END: begin
          si_q   <= si_n;
          vs_q   <= vs_n;
          sum_q  <= sum_n;
          tick_q <= '0;
          if (fin) begin
            ph_q       <= PH_IDLE;
            res_done_q <= 1'b1;
            res_vc_q   <= vs_n;
            if (vs_n != '0) begin
              div_go_q  <= 1'b1;
              div_dvd_q <= PROD_W'(sum_n);
              div_dsr_q <= DSR_W'(vs_n);
              ctl_q     <= C_AVG;
            end else begin
              res_status_q <= (run_len == SC_W'(1)) ? code_eff : ST_NONE;
              ctl_q        <= C_OUT;
            end
          end else begin
            ph_q  <= ph_guard;
            ctl_q <= C_OUT;
          end
        end
        C_AVG: begin
          div_go_q <= 1'b0;
          if (div_rsp.done) begin
            res_dist_q <= div_rsp.quotient[DIST_W-1:0];
            ctl_q      <= C_OUT;
          end
        end
        C_OUT: begin
          if (!out_valid_q || out_o.ready) begin
            out_valid_q <= 1'b1;
            o_trig_q    <= res_trig_q;
            o_done_q    <= res_done_q;
            o_status_q  <= res_status_q;
            o_dist_q    <= res_dist_q;
            o_vc_q      <= res_vc_q;
            ctl_q       <= C_IN;
          end
        end
        default: ctl_q <= C_IN;
      endcase
    end
  end

  assign div_req.go       = div_go_q;
  assign div_req.dividend = div_dvd_q;
  assign div_req.divisor  = div_dsr_q;

  uer_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  assign in_i.ready        = (ctl_q == C_IN);
  assign out_o.valid       = out_valid_q;
  assign out_o.trigger     = o_trig_q;
  assign out_o.done_res    = o_done_q;
  assign out_o.status      = o_status_q;
  assign out_o.distance_q4 = o_dist_q;
  assign out_o.valid_count = o_vc_q;

`ifndef SYNTHESIS
  a_quiet_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !o_done_q) |->
      (o_status_q == ST_OK && o_dist_q == '0 && o_vc_q == '0))
    else $error("result fields set on a tick that ends no run");

  a_ok_has_samples: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && o_done_q) |-> ((o_vc_q != '0) == (o_status_q == ST_OK)))
    else $error("status disagrees with valid sample count");

  a_no_trig_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !(o_trig_q && o_done_q))
    else $error("run finished during the trigger pulse");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready) |=> ctl_q != C_IN)
    else $error("accepted word left no work behind");

  a_vs_le_si: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vs_q <= si_q)
    else $error("more valid samples than measurements");
`endif

endmodule

[test/tb_ultrasonic_echo_ranger.sv]
module tb_ultrasonic_echo_ranger;
  import uer_pkg::*;

  localparam int CLK_PERIOD = 12;
  localparam int TRIG_TICKS = 10;
  localparam int MAX_RUN    = 16;
  localparam int HOLD_LEN   = 400;
  localparam int MAX_PRINTS = 40;

  localparam int          SOUND_BASE_Q8  = 84813;
  localparam int          SOUND_SLOPE_Q4 = 155;
  localparam longint      TOF_SCALE      = 320000;
  localparam logic [IDX_W-1:0] REG_UNUSED = 3'd7;

  typedef enum logic [2:0] {RG_IDLE, RG_GUARD, RG_TRIG, RG_WAIT, RG_COUNT} ranger_phase_e;

  typedef struct packed {
    logic start_req;
    logic echo;
  } tick_t;

  typedef struct packed {
    logic              trigger;
    logic              done_res;
    logic [ST_W-1:0]   status;
    logic [DIST_W-1:0] distance_q4;
    logic [SC_W-1:0]   valid_count;
  } echo_word_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic             cfg_we = 1'b0;
  logic [IDX_W-1:0] cfg_idx = '0;
  logic [CFG_W-1:0] cfg_data = '0;

  logic drv_valid = 1'b0;
  logic drv_start = 1'b0;
  logic drv_echo = 1'b0;
  logic rdy = 1'b0;

  uer_in_if  in_if ();
  uer_out_if out_if ();

  assign in_if.valid     = drv_valid;
  assign in_if.start_req = drv_start;
  assign in_if.echo      = drv_echo;
  assign out_if.ready    = rdy;

  ultrasonic_echo_ranger #(
    .TRIGGER_TICKS(TRIG_TICKS),
    .MAX_SAMPLES  (MAX_RUN)
  ) u_top (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_we_i  (cfg_we),
    .cfg_idx_i (cfg_idx),
    .cfg_data_i(cfg_data),
    .in_i      (in_if),
    .out_o     (out_if)
  );

  // register copies, reset values
  logic signed [TEMP_W-1:0] temp_q4   = 12'sd320;
  logic [TIME_W-1:0]        start_to  = 16'd10000;
  logic [TIME_W-1:0]        end_to    = 16'd38000;
  logic [TIME_W-1:0]        guard_gap = 16'd60000;
  logic [SC_W-1:0]          scount    = 5'd1;
  logic [DIST_W-1:0]        min_d     = 14'd320;
  logic [DIST_W-1:0]        max_d     = 14'd9600;

  // ranger state
  ranger_phase_e   ph = RG_IDLE;
  int              tick_cnt = 0;
  int              smp_idx = 0;
  int              n_valid = 0;
  int              dist_sum = 0;
  logic [ST_W-1:0] last_st = ST_OK;

  tick_t      tick_q[$];
  echo_word_t ranging_q[$];
  echo_word_t seen_want;

  int errors = 0;
  int hold_asks = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int cyc = 0;
  int burst_left = 0;
  int gap_left = 0;

  initial begin
    forever #(CLK_PERIOD / 2) clk_i = ~clk_i;
  end

  initial begin
    #(CLK_PERIOD * 1500000);
    $display("TEST FAILED");
    $finish;
  end

  function automatic int run_len();
    if (scount == 0) return 1;
    if (scount > MAX_RUN) return MAX_RUN;
    return scount;
  endfunction

  function automatic void begin_guard();
    tick_cnt = 0;
    ph = (guard_gap == 0) ? RG_TRIG : RG_GUARD;
  endfunction

  // closes one measurement, returns 1 when the run is over
  function automatic bit close_sample(input logic [ST_W-1:0] code, input int ticks);
    longint spd;
    longint d;
    int celsius_q4;
    logic [ST_W-1:0] st;
    st = code;
    if (code == ST_OK) begin
      celsius_q4 = temp_q4;
      spd = SOUND_BASE_Q8 + ((SOUND_SLOPE_Q4 * celsius_q4) >>> 4);
      d = (longint'(ticks) * spd) / TOF_SCALE;
      if (d < longint'(min_d) || d > longint'(max_d)) begin
        st = ST_RANGE;
      end else begin
        dist_sum += int'(d);
        n_valid++;
      end
    end
    last_st = st;
    smp_idx++;
    if (smp_idx >= run_len()) begin
      ph = RG_IDLE;
      tick_cnt = 0;
      return 1'b1;
    end
    begin_guard();
    return 1'b0;
  endfunction

  function automatic echo_word_t ranger_tick(input logic start, input logic echo);
    echo_word_t word;
    bit done;
    word = '0;
    done = 1'b0;
    word.trigger = (ph == RG_TRIG);
    case (ph)
      RG_IDLE: begin
        if (start) begin
          smp_idx = 0;
          n_valid = 0;
          dist_sum = 0;
          last_st = ST_OK;
          begin_guard();
        end
      end
      RG_GUARD: begin
        tick_cnt++;
        if (tick_cnt >= guard_gap) begin
          tick_cnt = 0;
          ph = RG_TRIG;
        end
      end
      RG_TRIG: begin
        tick_cnt++;
        if (tick_cnt >= TRIG_TICKS) begin
          tick_cnt = 0;
          ph = RG_WAIT;
        end
      end
      RG_WAIT: begin
        if (echo) begin
          tick_cnt = 0;
          ph = RG_COUNT;
        end else begin
          tick_cnt++;
          if (tick_cnt >= start_to) done = close_sample(ST_START_TO, 0);
        end
      end
      default: begin
        if (!echo) begin
          done = close_sample(ST_OK, tick_cnt);
        end else begin
          tick_cnt++;
          if (tick_cnt >= end_to) done = close_sample(ST_END_TO, 0);
        end
      end
    endcase
    if (done) begin
      word.done_res = 1'b1;
      if (n_valid > 0) begin
        word.status = ST_OK;
        word.distance_q4 = DIST_W'(dist_sum / n_valid);
      end else begin
        word.status = (run_len() == 1) ? last_st : ST_NONE;
      end
      word.valid_count = SC_W'(n_valid);
    end
    return word;
  endfunction

  function automatic void check_field(input string what, input logic [15:0] want,
                                      input logic [15:0] got);
    if (want !== got) begin
      errors++;
      if (errors <= MAX_PRINTS)
        $display("%0t %s mismatch: expected %0d, got %0d", $time, what, want, got);
    end
  endfunction

  function automatic logic busy_start();
    return $urandom_range(0, 5) == 0;
  endfunction

  function automatic void push_tick(input logic s, input logic e);
    tick_t t;
    t.start_req = s;
    t.echo = e;
    tick_q.push_back(t);
  endfunction

  // one measurement: guard and trigger ticks, then lo_ticks low, then hi_ticks high, each cut at its timeout
  function automatic void plan_sample(input int lo_ticks, input int hi_ticks);
    int start_lim;
    int end_lim;
    start_lim = (start_to == 0) ? 1 : start_to;
    end_lim = (end_to == 0) ? 1 : end_to;
    repeat (guard_gap + TRIG_TICKS) push_tick(busy_start(), 1'($urandom_range(0, 1)));
    if (lo_ticks >= start_lim) begin
      repeat (start_lim) push_tick(busy_start(), 1'b0);
      return;
    end
    repeat (lo_ticks) push_tick(busy_start(), 1'b0);
    push_tick(busy_start(), 1'b1);
    if (hi_ticks >= end_lim) begin
      repeat (end_lim) push_tick(busy_start(), 1'b1);
      return;
    end
    repeat (hi_ticks) push_tick(busy_start(), 1'b1);
    push_tick(busy_start(), 1'b0);
  endfunction

  function automatic void plan_run();
    push_tick(1'b1, 1'($urandom_range(0, 1)));
    for (int s = 0; s < run_len(); s++)
      plan_sample(($urandom_range(0, 9) == 0) ? 40 : $urandom_range(0, 4),
                  ($urandom_range(0, 9) == 0) ? 60 : $urandom_range(0, 24));
  endfunction

  task automatic drain();
    while (tick_q.size() != 0 || drv_valid || ranging_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    @(posedge clk_i);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= val;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    case (idx)
      REG_TEMP:     temp_q4 = val[TEMP_W-1:0];
      REG_START_TO: start_to = val;
      REG_END_TO:   end_to = val;
      REG_GUARD:    guard_gap = val;
      REG_SCOUNT:   scount = val[SC_W-1:0];
      REG_MIN:      min_d = val[DIST_W-1:0];
      REG_MAX:      max_d = val[DIST_W-1:0];
      default: ;
    endcase
  endtask

  // sender: bursts of words with random gaps
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      drv_valid <= 1'b0;
      drv_start <= 1'b0;
      drv_echo <= 1'b0;
      burst_left = 0;
      gap_left = 0;
      ph = RG_IDLE;
      tick_cnt = 0;
      smp_idx = 0;
      n_valid = 0;
      dist_sum = 0;
      last_st = ST_OK;
    end else begin
      if (drv_valid && in_if.ready) ranging_q.push_back(ranger_tick(drv_start, drv_echo));
      if (!drv_valid || in_if.ready) begin
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 24);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end
        if (gap_left > 0) begin
          gap_left--;
          drv_valid <= 1'b0;
        end else if (tick_q.size() != 0) begin
          {drv_start, drv_echo} <= tick_q.pop_front();
          drv_valid <= 1'b1;
          burst_left--;
        end else begin
          drv_valid <= 1'b0;
        end
      end
    end
  end

  // receiver: checks each word, stalls on its own pattern
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rdy <= 1'b0;
      cyc = 0;
      hold_left = 0;
      hold_seen = 0;
    end else begin
      if (out_if.valid && rdy) begin
        if (ranging_q.size() == 0) begin
          errors++;
          if (errors <= MAX_PRINTS)
            $display("%0t unexpected word: expected none, got %b %b %0d %0d %0d", $time,
                     out_if.trigger, out_if.done_res, out_if.status, out_if.distance_q4,
                     out_if.valid_count);
        end else begin
          seen_want = ranging_q.pop_front();
          check_field("trigger", 16'(seen_want.trigger), 16'(out_if.trigger));
          check_field("done_res", 16'(seen_want.done_res), 16'(out_if.done_res));
          check_field("status", 16'(seen_want.status), 16'(out_if.status));
          check_field("distance_q4", 16'(seen_want.distance_q4), 16'(out_if.distance_q4));
          check_field("valid_count", 16'(seen_want.valid_count), 16'(out_if.valid_count));
        end
      end
      cyc++;
      if (hold_seen != hold_asks) begin
        hold_seen = hold_asks;
        hold_left = HOLD_LEN;
      end
      if (hold_left > 0) begin
        hold_left--;
        rdy <= 1'b0;
      end else if (cyc[9:8] == 2'b00) begin
        rdy <= 1'b1;
      end else begin
        rdy <= ($urandom_range(0, 3) != 0);
      end
    end
  end

  initial begin
    int runs;
    int pick;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // idle ticks under reset settings
    push_tick(1'b0, 1'b0);
    push_tick(1'b0, 1'b1);
    push_tick(1'b0, 1'b0);
    drain();

    // coldest air, zero timeouts act as one tick, no guard
    write_reg(REG_TEMP, 16'hFD80);
    write_reg(REG_START_TO, 16'd0);
    write_reg(REG_END_TO, 16'd0);
    write_reg(REG_GUARD, 16'd0);
    write_reg(REG_SCOUNT, 16'd1);
    write_reg(REG_MIN, 16'd0);
    write_reg(REG_MAX, 16'd9600);
    push_tick(1'b1, 1'b0);
    plan_sample(0, 0);
    push_tick(1'b1, 1'b1);
    plan_sample(5, 0);
    push_tick(1'b1, 1'b0);
    plan_sample(0, 5);
    drain();

    // write to an index with no register behind it
    write_reg(REG_UNUSED, 16'hFFFF);
    push_tick(1'b1, 1'b0);
    plan_sample(0, 0);
    drain();

    // hottest air, widest timeouts, pulse under a long receiver hold-off
    write_reg(REG_TEMP, 16'h0550);
    write_reg(REG_START_TO, 16'hFFFF);
    write_reg(REG_END_TO, 16'hFFFF);
    hold_asks++;
    push_tick(1'b1, 1'b0);
    plan_sample(4, 20);
    drain();

    // minimum above maximum rejects everything
    write_reg(REG_MIN, 16'd9600);
    write_reg(REG_MAX, 16'd0);
    push_tick(1'b1, 1'b0);
    plan_sample(1, 8);
    drain();

    // three samples: one good, then none good
    write_reg(REG_START_TO, 16'd5);
    write_reg(REG_END_TO, 16'd12);
    write_reg(REG_SCOUNT, 16'd3);
    write_reg(REG_MIN, 16'd1);
    write_reg(REG_MAX, 16'd9600);
    push_tick(1'b1, 1'b0);
    plan_sample(10, 0);
    plan_sample(0, 100);
    plan_sample(0, 5);
    push_tick(1'b1, 1'b0);
    plan_sample(10, 0);
    plan_sample(0, 100);
    plan_sample(0, 0);
    drain();

    // oversized sample count runs the full sixteen, then a zero sample count
    write_reg(REG_MIN, 16'd0);
    write_reg(REG_SCOUNT, 16'd31);
    write_reg(REG_START_TO, 16'd1);
    write_reg(REG_END_TO, 16'd2);
    plan_run();
    drain();
    write_reg(REG_SCOUNT, 16'd0);
    write_reg(REG_START_TO, 16'd5);
    write_reg(REG_END_TO, 16'd30);
    plan_run();
    drain();

    // longest guard, cut short by a write in the middle of the run
    write_reg(REG_SCOUNT, 16'd1);
    write_reg(REG_GUARD, 16'hFFFF);
    push_tick(1'b1, 1'b0);
    repeat (20) push_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    drain();
    write_reg(REG_GUARD, 16'd0);
    push_tick(1'b0, 1'b1);
    plan_sample(2, 10);
    drain();

    // random runs with short timings
    runs = 0;
    while (runs < 4) begin
      if (runs % 2 == 0) begin
        drain();
        pick = $urandom_range(0, 2000);
        write_reg(REG_TEMP, CFG_W'(pick - 640));
        write_reg(REG_START_TO,
                  CFG_W'(($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 8)));
        write_reg(REG_END_TO, CFG_W'($urandom_range(0, 12)));
        write_reg(REG_GUARD, CFG_W'($urandom_range(0, 4)));
        pick = $urandom_range(0, 10);
        write_reg(REG_SCOUNT, CFG_W'((pick == 10) ? 0 : $urandom_range(1, 3)));
        write_reg(REG_MIN, CFG_W'($urandom_range(0, 4)));
        write_reg(REG_MAX, CFG_W'($urandom_range(0, 10)));
      end
      if ($urandom_range(0, 9) == 0) begin
        // broken sequence: random start and echo levels
        repeat ($urandom_range(5, 30))
          push_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      end else begin
        repeat ($urandom_range(0, 3)) tick_q.push_back('{1'b0, 1'($urandom_range(0, 1))});
        plan_run();
      end
      runs++;
    end

    drain();
    repeat (200) @(posedge clk_i);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

[sim.f]
design/uer_pkg.sv
design/uer_if.sv
design/uer_div.sv
design/ultrasonic_echo_ranger.sv
test/tb_ultrasonic_echo_ranger.sv
